/* sv/wmdb_pkg.sv */
// Shared constants and types for the window median depth back-projection block.
package wmdb_pkg;

  localparam int WindowHalf = 4;
  localparam int PixelBits  = 12;
  localparam int Side       = 2 * WindowHalf + 1;
  localparam int Capacity   = Side * Side;
  localparam int AddrW      = $clog2(Capacity);
  localparam int CountW     = $clog2(Capacity + 1);

  // Register indexes
  localparam logic [2:0] RegDepthMin = 3'd0;
  localparam logic [2:0] RegDepthMax = 3'd1;
  localparam logic [2:0] RegFocalX   = 3'd2;
  localparam logic [2:0] RegFocalY   = 3'd3;
  localparam logic [2:0] RegPrincX   = 3'd4;
  localparam logic [2:0] RegPrincY   = 3'd5;

  // Divider request
  typedef struct packed {
    logic        start;
    logic [47:0] mag;
    logic [17:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] quot;
  } div_rsp_t;

endpackage

/* sv/window_median_depth_backproject.sv */
// Top level: sample store, rank-select median sequencer and back-projection.
// A non-last sample is taken while idle. A last sample with n valid samples passes a
// check state, a rank search (one compare per cycle), the two serial divisions and an
// output state; with no valid sample or a zero focal length the window goes from the
// check state straight to output. Input stall is high while a window closes.
// Reset (rst_n, synchronous) restores register defaults, empties the store.
module window_median_depth_backproject (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_depth_mm,
  input  logic        in_sample_finite,
  input  logic [11:0] in_center_col,
  input  logic [11:0] in_center_row,
  input  logic        in_last_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic [15:0] out_median_depth_mm,
  output logic signed [31:0] out_point_x_mm,
  output logic signed [31:0] out_point_y_mm,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = wmdb_pkg::AddrW;
  localparam int CW = wmdb_pkg::CountW;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StRdI   = 4'd1;
  localparam logic [3:0] StRdJ   = 4'd2;
  localparam logic [3:0] StCmp   = 4'd3;
  localparam logic [3:0] StCheck = 4'd4;
  localparam logic [3:0] StMulX  = 4'd5;
  localparam logic [3:0] StDivX  = 4'd6;
  localparam logic [3:0] StMulY  = 4'd7;
  localparam logic [3:0] StDivY  = 4'd8;
  localparam logic [3:0] StOut   = 4'd9;
  localparam logic [3:0] StWaitX = 4'd10;
  localparam logic [3:0] StWaitY = 4'd11;

  // Configuration registers
  logic [15:0] dmin_r, dmax_r, px_r, py_r;
  logic [17:0] fx_r, fy_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dmin_r <= 16'd200;
      dmax_r <= 16'd8000;
      fx_r   <= 18'd9600;
      fy_r   <= 18'd9600;
      px_r   <= 16'd5120;
      py_r   <= 16'd3840;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        wmdb_pkg::RegDepthMin: dmin_r <= cfg_pwdata[15:0];
        wmdb_pkg::RegDepthMax: dmax_r <= cfg_pwdata[15:0];
        wmdb_pkg::RegFocalX:   fx_r   <= cfg_pwdata[17:0];
        wmdb_pkg::RegFocalY:   fy_r   <= cfg_pwdata[17:0];
        wmdb_pkg::RegPrincX:   px_r   <= cfg_pwdata[15:0];
        wmdb_pkg::RegPrincY:   py_r   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[1:0] == 2'b00) begin
      unique case (cfg_idx)
        wmdb_pkg::RegDepthMin: cfg_prdata = {16'd0, dmin_r};
        wmdb_pkg::RegDepthMax: cfg_prdata = {16'd0, dmax_r};
        wmdb_pkg::RegFocalX:   cfg_prdata = {14'd0, fx_r};
        wmdb_pkg::RegFocalY:   cfg_prdata = {14'd0, fy_r};
        wmdb_pkg::RegPrincX:   cfg_prdata = {16'd0, px_r};
        wmdb_pkg::RegPrincY:   cfg_prdata = {16'd0, py_r};
        default:               cfg_prdata = '0;
      endcase
    end
  end

  // Sequencer state
  logic [3:0]    st_r;
  logic [CW-1:0] cnt_r, i_r, j_r;
  logic [CW-1:0] less_r, eq_r;
  logic [15:0]   v_r, z_r;
  logic [11:0]   col_r, row_r;
  logic          ov_r;
  logic          found_r;
  logic [15:0]   med_r;
  logic signed [31:0] ox_r, oy_r;
  logic          neg_r;
  logic [47:0]   mag_r;
  logic [15:0]   rdata_r;

  // Output register, parts the result side from the sequencer
  logic          out_found_r;
  logic [15:0]   out_med_r;
  logic signed [31:0] out_x_r, out_y_r;

  // Sample store
  logic [15:0] store [wmdb_pkg::Capacity];
  logic        acc, sample_ok;
  logic [AW-1:0] rd_addr;

  assign in_stall  = (st_r != StIdle);
  assign acc       = in_valid && !in_stall;
  assign sample_ok = in_sample_finite && (in_depth_mm > dmin_r) && (in_depth_mm < dmax_r)
                     && (cnt_r < CW'(wmdb_pkg::Capacity));
  assign rd_addr   = (st_r == StRdI) ? i_r[AW-1:0] : j_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (acc && sample_ok) store[cnt_r[AW-1:0]] <= in_depth_mm;
    rdata_r <= store[rd_addr];
  end

  // Rank test on the counts including the current compare
  logic [CW-1:0] less_fin, eq_fin, half_n;
  logic          rank_hit;

  assign less_fin = less_r + CW'(rdata_r < v_r);
  assign eq_fin   = eq_r + CW'(rdata_r == v_r);
  assign half_n   = cnt_r >> 1;
  assign rank_hit = (less_fin <= half_n) && (half_n < less_fin + eq_fin);

  // Divider
  wmdb_pkg::div_req_t dreq;
  wmdb_pkg::div_rsp_t drsp;
  wmdb_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // Shared multiplier: signed offset times depth
  logic signed [17:0] off;
  logic signed [34:0] prod;
  logic [17:0]        fsel;
  logic [47:0]        qsum;
  logic signed [31:0] sat;

  always_comb begin
    if (st_r == StMulX) off = $signed({2'b00, col_r, 4'b0000}) - $signed({2'b00, px_r});
    else                off = $signed({2'b00, row_r, 4'b0000}) - $signed({2'b00, py_r});
    prod = off * $signed({1'b0, z_r});
    fsel = (st_r == StDivX || st_r == StWaitX) ? fx_r : fy_r;
    dreq.start   = (st_r == StDivX) || (st_r == StDivY);
    dreq.mag     = mag_r + 48'(fsel >> 1);
    dreq.divisor = fsel;
    qsum = drsp.quot;
    if (neg_r) sat = (qsum > 48'd2147483648) ? 32'sh80000000 : -$signed(qsum[31:0]);
    else       sat = (qsum > 48'd2147483647) ? 32'sh7fffffff : $signed(qsum[31:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= StIdle;
      cnt_r <= '0;
      ov_r  <= 1'b0;
      col_r <= '0;
      row_r <= '0;
    end else begin
      // Result valid: set when a result is loaded, cleared on its transaction
      if (st_r == StOut && (!ov_r || !out_stall)) ov_r <= 1'b1;
      else if (ov_r && !out_stall)               ov_r <= 1'b0;
      unique case (st_r)
        StIdle: begin
          if (acc) begin
            col_r <= in_center_col[wmdb_pkg::PixelBits-1:0];
            row_r <= in_center_row[wmdb_pkg::PixelBits-1:0];
            if (in_last_sample) begin
              cnt_r <= '0;
              i_r   <= '0;
              if (sample_ok) j_r <= cnt_r + CW'(1);
              else           j_r <= cnt_r;
              // j_r holds n here until the search starts
              st_r <= StCheck;
            end else if (sample_ok) begin
              cnt_r <= cnt_r + CW'(1);
            end
          end
        end
        StCheck: begin
          // capture n, then decide
          cnt_r <= j_r;
          if (j_r == '0 || fx_r == '0 || fy_r == '0) begin
            found_r <= 1'b0;
            med_r   <= '0;
            ox_r    <= '0;
            oy_r    <= '0;
            st_r    <= StOut;
          end else begin
            st_r <= StRdI;
          end
        end
        StRdI: begin
          j_r    <= '0;
          less_r <= '0;
          eq_r   <= '0;
          st_r   <= StRdJ;
        end
        StRdJ: begin
          v_r  <= rdata_r;
          j_r  <= j_r + CW'(1);
          st_r <= StCmp;
        end
        StCmp: begin
          // rdata_r holds store[j-1]
          less_r <= less_fin;
          eq_r   <= eq_fin;
          if (j_r == cnt_r) begin
            if (rank_hit) begin
              st_r <= StMulX;
            end else begin
              st_r <= StRdI;
              i_r  <= i_r + CW'(1);
            end
            z_r <= v_r;
          end else begin
            j_r <= j_r + CW'(1);
          end
        end
        StMulX: begin
          neg_r <= prod[34];
          mag_r <= 48'(prod[34] ? -prod : prod);
          st_r  <= StDivX;
        end
        StDivX: st_r <= StWaitX;
        StWaitX: if (drsp.done) begin
          ox_r <= sat;
          st_r <= StMulY;
        end
        StMulY: begin
          neg_r <= prod[34];
          mag_r <= 48'(prod[34] ? -prod : prod);
          st_r  <= StDivY;
        end
        StDivY: st_r <= StWaitY;
        StWaitY: if (drsp.done) begin
          oy_r    <= sat;
          found_r <= 1'b1;
          med_r   <= z_r;
          st_r    <= StOut;
        end
        StOut: begin
          // wait until the previous result has gone
          if (!ov_r || !out_stall) begin
            out_found_r <= found_r;
            out_med_r   <= med_r;
            out_x_r     <= ox_r;
            out_y_r     <= oy_r;
            cnt_r       <= '0;
            st_r        <= StIdle;
          end
        end
        default: st_r <= StIdle;
      endcase
    end
  end

  assign out_valid           = ov_r;
  assign out_found           = out_found_r;
  assign out_median_depth_mm = out_med_r;
  assign out_point_x_mm      = out_x_r;
  assign out_point_y_mm      = out_y_r;

  // Store never overfills
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(wmdb_pkg::Capacity)) else $error("sample count overflow");
  // No input taken while a window closes
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != StIdle) |-> in_stall) else $error("input accepted while busy");
  // Found result carries nonzero depth
  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_median_depth_mm != '0)) else $error("found with zero z");

endmodule

/* sv/wmdb_div.sv */
// Restoring divider, one quotient bit per cycle.
module wmdb_div (
  input  logic              clk,
  input  logic              rst_n,
  input  wmdb_pkg::div_req_t req,
  output wmdb_pkg::div_rsp_t rsp
);

  logic [47:0] quot_r, quot_nxt;
  logic [18:0] rem_r, rem_nxt;
  logic [17:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [18:0] shifted;
  logic [19:0] diff;

  // One shift-subtract step
  always_comb begin
    shifted  = {rem_r[17:0], quot_r[47]};
    diff     = {1'b0, shifted} - {2'b00, dvs_r};
    quot_nxt = {quot_r[46:0], ~diff[19]};
    rem_nxt  = diff[19] ? shifted : diff[18:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // done pulses for one cycle after the last quotient bit
      done_r <= busy_r && !req.start && (cnt_r == 6'd47);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd47) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot_r <= req.mag;
      rem_r  <= '0;
      dvs_r  <= req.divisor;
    end else if (busy_r) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule
